// File: rtl/scac_pkg.sv
// Package for the self-calibrating axis classifier: parameter defaults, command and
// direction codes, controller states, control structs and the hat sine table.
// No dependencies.
`timescale 1ns / 1ps

package scac_pkg;

    localparam int CAL_AXES   = 6;
    localparam int TOTAL_AXES = 8;
    localparam int POS_BITS   = 16;

    localparam int CMD_W      = 2;
    localparam int AXIS_W     = 3;
    localparam int ANGLE_W    = 16;
    localparam int DIR_W      = 2;
    localparam int STRENGTH_W = 7;
    localparam int DEG_W      = 9;
    localparam int LEVEL_W    = 8;

    localparam logic [CMD_W-1:0] CMD_CLASSIFY = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd2;

    localparam logic [DIR_W-1:0] DIR_MIDDLE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LOW    = 2'd1;
    localparam logic [DIR_W-1:0] DIR_HIGH   = 2'd2;

    localparam logic [ANGLE_W-1:0] HAT_CENTRED = 16'hFFFF;
    localparam int                 DEG_RECIP   = 83887;
    localparam int                 DEG_SHIFT   = 23;
    localparam int                 DEG_PROD_W  = 33;
    localparam int                 DEG_QUOT_W  = 10;
    localparam logic [DEG_QUOT_W-1:0] FULL_TURN = 10'd360;

    localparam logic [LEVEL_W-1:0] LEVEL_MID  = 8'd100;
    localparam logic [LEVEL_W-1:0] HAT_HIGH   = 8'd130;
    localparam logic [LEVEL_W-1:0] HAT_LOW    = 8'd70;
    localparam logic [6:0]         PERCENT    = 7'd100;

    localparam int DIV_STEPS = 7;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_PREP,
        ST_BAND,
        ST_CLASS,
        ST_DIV,
        ST_OUT
    } scac_state_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic prep;
        logic band;
        logic classify;
        logic div_step;
        logic out_load;
    } scac_ctrl_t;

    typedef struct packed {
        logic need_div;
    } scac_stat_t;

    // Floor of 100 * sin(k degrees) for k from 0 to 90.
    localparam logic [6:0] QUARTER_SINE [0:90] = '{
        7'd0,  7'd1,  7'd3,  7'd5,  7'd6,  7'd8,  7'd10, 7'd12, 7'd13, 7'd15,
        7'd17, 7'd19, 7'd20, 7'd22, 7'd24, 7'd25, 7'd27, 7'd29, 7'd30, 7'd32,
        7'd34, 7'd35, 7'd37, 7'd39, 7'd40, 7'd42, 7'd43, 7'd45, 7'd46, 7'd48,
        7'd50, 7'd51, 7'd52, 7'd54, 7'd55, 7'd57, 7'd58, 7'd60, 7'd61, 7'd62,
        7'd64, 7'd65, 7'd66, 7'd68, 7'd69, 7'd70, 7'd71, 7'd73, 7'd74, 7'd75,
        7'd76, 7'd77, 7'd78, 7'd79, 7'd80, 7'd81, 7'd82, 7'd83, 7'd84, 7'd85,
        7'd86, 7'd87, 7'd88, 7'd89, 7'd89, 7'd90, 7'd91, 7'd92, 7'd92, 7'd93,
        7'd93, 7'd94, 7'd95, 7'd95, 7'd96, 7'd96, 7'd97, 7'd97, 7'd97, 7'd98,
        7'd98, 7'd98, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd100
    };

    // Truncated 100 + 100 * sin(b) for b in whole degrees below a full turn.
    function automatic logic [LEVEL_W-1:0] sine_level(input logic [DEG_W-1:0] b);
        logic [DEG_W-1:0]   c;
        logic [6:0]         k;
        logic [LEVEL_W-1:0] lvl;
        c = b - 9'd180;
        if (b == 9'd270)
        begin
            lvl = 8'd0;
        end
        else if (b <= 9'd180)
        begin
            k   = (b <= 9'd90) ? b[6:0] : 7'(9'd180 - b);
            lvl = 8'd100 + 8'(QUARTER_SINE[k]);
        end
        else
        begin
            k   = (c <= 9'd90) ? c[6:0] : 7'(9'd180 - c);
            lvl = 8'd99 - 8'(QUARTER_SINE[k]);
        end
        return lvl;
    endfunction

    function automatic logic [LEVEL_W-1:0] hat_level(input logic [DEG_W-1:0] deg,
                                                     input logic vertical);
        logic [DEG_W:0]     shifted;
        logic [DEG_W-1:0]   b;
        logic [LEVEL_W-1:0] lvl;
        shifted = {1'b0, deg} + 10'd270;
        b       = (shifted >= 10'd360) ? 9'(shifted - 10'd360) : shifted[DEG_W-1:0];
        if (!vertical)
        begin
            lvl = sine_level(deg);
        end
        else if (deg == 9'd120)
        begin
            lvl = 8'd149;
        end
        else
        begin
            lvl = sine_level(b);
        end
        return lvl;
    endfunction

endpackage

// File: rtl/scac_if.sv
// Channel interfaces for the axis classifier: the sample channel and the result channel.
// Depends on scac_pkg for the fixed field widths.
`timescale 1ns / 1ps

interface scac_in_if #(
    parameter int POS_BITS = scac_pkg::POS_BITS
) ();
    logic                              valid;
    logic                              ready;
    logic [scac_pkg::CMD_W-1:0]        cmd;
    logic [scac_pkg::AXIS_W-1:0]       axis;
    logic [POS_BITS-1:0]               position;
    logic [scac_pkg::ANGLE_W-1:0]      hat_angle;
    logic [POS_BITS-1:0]               load_min;
    logic [POS_BITS-1:0]               load_max;
    logic                              load_seen;

    modport source (
        output valid, cmd, axis, position, hat_angle, load_min, load_max, load_seen,
        input  ready
    );
    modport sink (
        input  valid, cmd, axis, position, hat_angle, load_min, load_max, load_seen,
        output ready
    );
endinterface

interface scac_out_if #(
    parameter int POS_BITS = scac_pkg::POS_BITS
) ();
    logic                              valid;
    logic                              ready;
    logic [scac_pkg::DIR_W-1:0]        direction;
    logic [scac_pkg::STRENGTH_W-1:0]   strength;
    logic [POS_BITS-1:0]               cal_min;
    logic [POS_BITS-1:0]               cal_max;
    logic                              cal_seen;

    modport source (
        output valid, direction, strength, cal_min, cal_max, cal_seen,
        input  ready
    );
    modport sink (
        input  valid, direction, strength, cal_min, cal_max, cal_seen,
        output ready
    );
endinterface

// File: rtl/scac_ctrl.sv
// Controller state machine of the axis classifier: sequences the datapath steps,
// counts divide steps and owns the result valid flag. Depends on scac_pkg.
`timescale 1ns / 1ps

module scac_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  scac_pkg::scac_stat_t stat,
    output scac_pkg::scac_ctrl_t ctl
);

    scac_pkg::scac_state_t state_reg;
    scac_pkg::scac_state_t state_next;
    logic [scac_pkg::CNT_W-1:0] cnt_reg;
    logic [scac_pkg::CNT_W-1:0] cnt_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;
    logic last_step;

    assign out_free  = !out_valid_reg || out_ready;
    assign last_step = (cnt_reg == scac_pkg::CNT_W'(scac_pkg::DIV_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            scac_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = scac_pkg::ST_UPDATE;
                end
            end
            scac_pkg::ST_UPDATE: state_next = scac_pkg::ST_PREP;
            scac_pkg::ST_PREP:   state_next = scac_pkg::ST_BAND;
            scac_pkg::ST_BAND:   state_next = scac_pkg::ST_CLASS;
            scac_pkg::ST_CLASS:
            begin
                state_next = stat.need_div ? scac_pkg::ST_DIV : scac_pkg::ST_OUT;
            end
            scac_pkg::ST_DIV:
            begin
                if (last_step)
                begin
                    state_next = scac_pkg::ST_OUT;
                end
            end
            scac_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = scac_pkg::ST_IDLE;
                end
            end
            default: state_next = scac_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl      = '0;
        in_ready = 1'b0;
        cnt_next = '0;
        case (state_reg)
            scac_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                ctl.capture = in_valid;
            end
            scac_pkg::ST_UPDATE: ctl.update = 1'b1;
            scac_pkg::ST_PREP:   ctl.prep = 1'b1;
            scac_pkg::ST_BAND:   ctl.band = 1'b1;
            scac_pkg::ST_CLASS:  ctl.classify = 1'b1;
            scac_pkg::ST_DIV:
            begin
                ctl.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
            end
            scac_pkg::ST_OUT:    ctl.out_load = out_free;
            default:             ctl = '0;
        endcase
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scac_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/scac_dp.sv
// Datapath of the axis classifier: calibration store, range and dead band, hat table,
// serial divider and result registers. Depends on scac_pkg.
`timescale 1ns / 1ps

module scac_dp #(
    parameter int CAL_AXES   = scac_pkg::CAL_AXES,
    parameter int TOTAL_AXES = scac_pkg::TOTAL_AXES,
    parameter int POS_BITS   = scac_pkg::POS_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  scac_pkg::scac_ctrl_t               ctl,
    output scac_pkg::scac_stat_t               stat,
    input  logic [scac_pkg::CMD_W-1:0]         cmd,
    input  logic [scac_pkg::AXIS_W-1:0]        axis,
    input  logic [POS_BITS-1:0]                position,
    input  logic [scac_pkg::ANGLE_W-1:0]       hat_angle,
    input  logic [POS_BITS-1:0]                load_min,
    input  logic [POS_BITS-1:0]                load_max,
    input  logic                               load_seen,
    output logic [scac_pkg::DIR_W-1:0]         direction,
    output logic [scac_pkg::STRENGTH_W-1:0]    strength,
    output logic [POS_BITS-1:0]                cal_min,
    output logic [POS_BITS-1:0]                cal_max,
    output logic                               cal_seen
);

    localparam int IDX_W = (CAL_AXES > 1) ? $clog2(CAL_AXES) : 1;
    localparam int NUM_W = POS_BITS + scac_pkg::STRENGTH_W;
    localparam int PROD_W = 2 * POS_BITS;
    localparam logic [POS_BITS-1:0] BAND_RECIP =
        POS_BITS'(((64'd1 << (POS_BITS + 2)) + 64'd4) / 64'd5);

    logic [scac_pkg::CMD_W-1:0]   cmd_reg;
    logic [scac_pkg::AXIS_W-1:0]  axis_reg;
    logic [POS_BITS-1:0]          pos_reg;
    logic [scac_pkg::ANGLE_W-1:0] angle_reg;
    logic [POS_BITS-1:0]          load_min_reg;
    logic [POS_BITS-1:0]          load_max_reg;
    logic                         load_seen_reg;

    logic [POS_BITS-1:0] low_reg [CAL_AXES];
    logic [POS_BITS-1:0] high_reg [CAL_AXES];
    logic [CAL_AXES-1:0] seen_reg;
    logic                was_seen_reg;

    logic [scac_pkg::DEG_QUOT_W-1:0] quot_reg;
    logic [scac_pkg::DEG_W-1:0]      deg_reg;
    logic [POS_BITS-1:0]             centre_reg;
    logic [POS_BITS-1:0]             range_reg;
    logic [POS_BITS-1:0]             band_reg;
    logic [NUM_W-1:0]                rem_reg;
    logic [NUM_W-1:0]                dsr_reg;
    logic [scac_pkg::DIR_W-1:0]      dir_reg;
    logic [scac_pkg::STRENGTH_W-1:0] str_reg;

    logic [scac_pkg::DIR_W-1:0]      res_dir_reg;
    logic [scac_pkg::STRENGTH_W-1:0] res_str_reg;
    logic [POS_BITS-1:0]             res_min_reg;
    logic [POS_BITS-1:0]             res_max_reg;
    logic                            res_seen_reg;

    logic [IDX_W-1:0]               idx;
    logic                           analog;
    logic                           present;
    logic                           vertical;
    logic [scac_pkg::DEG_PROD_W-1:0] deg_prod;
    logic [POS_BITS:0]              pair_sum;
    logic [POS_BITS-1:0]            centre_next;
    logic [PROD_W-1:0]              band_prod;
    logic [scac_pkg::LEVEL_W-1:0]   level;
    logic [scac_pkg::LEVEL_W-1:0]   level_dev;
    logic                           below;
    logic                           above;
    logic [POS_BITS-1:0]            dev;
    logic [scac_pkg::DIR_W-1:0]     dir_next;
    logic [scac_pkg::STRENGTH_W-1:0] str_next;
    logic                           need_div;
    logic                           sub_ok;

    assign idx      = axis_reg[IDX_W-1:0];
    assign analog   = ({1'b0, axis_reg} < 4'(CAL_AXES));
    assign present  = ({1'b0, axis_reg} < 4'(TOTAL_AXES));
    assign vertical = ({1'b0, axis_reg} == 4'(CAL_AXES + 1));

    assign deg_prod    = scac_pkg::DEG_PROD_W'(angle_reg)
                       * scac_pkg::DEG_PROD_W'(scac_pkg::DEG_RECIP);
    assign pair_sum    = {1'b0, low_reg[idx]} + {1'b0, high_reg[idx]};
    assign centre_next = pair_sum[POS_BITS:1];
    assign band_prod   = {{POS_BITS{1'b0}}, range_reg} * {{POS_BITS{1'b0}}, BAND_RECIP};

    always_comb
    begin
        level = (angle_reg == scac_pkg::HAT_CENTRED) ? scac_pkg::LEVEL_MID
              : scac_pkg::hat_level(deg_reg, vertical);
        level_dev = (level >= scac_pkg::LEVEL_MID) ? (level - scac_pkg::LEVEL_MID)
                  : (scac_pkg::LEVEL_MID - level);
        below = ({1'b0, pos_reg} + {1'b0, band_reg}) < {1'b0, centre_reg};
        above = {1'b0, pos_reg} > ({1'b0, centre_reg} + {1'b0, band_reg});
        dev   = below ? (centre_reg - pos_reg) : (pos_reg - centre_reg);
        dir_next = scac_pkg::DIR_MIDDLE;
        str_next = '0;
        need_div = 1'b0;
        if (cmd_reg == scac_pkg::CMD_CLASSIFY && analog && was_seen_reg)
        begin
            if (below)
            begin
                dir_next = scac_pkg::DIR_LOW;
            end
            else if (above)
            begin
                dir_next = scac_pkg::DIR_HIGH;
            end
            need_div = (below || above) && (range_reg != '0);
        end
        else if (cmd_reg == scac_pkg::CMD_CLASSIFY && !analog && present)
        begin
            str_next = scac_pkg::STRENGTH_W'(level_dev);
            if (level > scac_pkg::HAT_HIGH)
            begin
                dir_next = scac_pkg::DIR_HIGH;
            end
            else if (level < scac_pkg::HAT_LOW)
            begin
                dir_next = scac_pkg::DIR_LOW;
            end
        end
    end

    assign stat.need_div = need_div;
    assign sub_ok = (rem_reg >= dsr_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg       <= cmd;
            axis_reg      <= axis;
            pos_reg       <= position;
            angle_reg     <= hat_angle;
            load_min_reg  <= load_min;
            load_max_reg  <= load_max;
            load_seen_reg <= load_seen;
        end
        if (ctl.update)
        begin
            quot_reg <= deg_prod[scac_pkg::DEG_PROD_W-1:scac_pkg::DEG_SHIFT];
            if (cmd_reg == scac_pkg::CMD_LOAD && analog)
            begin
                low_reg[idx]  <= load_min_reg;
                high_reg[idx] <= load_max_reg;
            end
            else if (cmd_reg == scac_pkg::CMD_CLASSIFY && analog)
            begin
                if (!seen_reg[idx] || pos_reg < low_reg[idx])
                begin
                    low_reg[idx] <= pos_reg;
                end
                if (!seen_reg[idx] || pos_reg > high_reg[idx])
                begin
                    high_reg[idx] <= pos_reg;
                end
            end
        end
        if (ctl.prep)
        begin
            centre_reg <= centre_next;
            range_reg  <= high_reg[idx] - centre_next;
            deg_reg    <= (quot_reg >= scac_pkg::FULL_TURN)
                        ? scac_pkg::DEG_W'(quot_reg - scac_pkg::FULL_TURN)
                        : quot_reg[scac_pkg::DEG_W-1:0];
        end
        if (ctl.band)
        begin
            band_reg <= POS_BITS'(band_prod >> (POS_BITS + 2));
        end
        if (ctl.classify)
        begin
            dir_reg <= dir_next;
            str_reg <= str_next;
            rem_reg <= NUM_W'(dev) * NUM_W'(scac_pkg::PERCENT);
            dsr_reg <= NUM_W'(range_reg) << (scac_pkg::DIV_STEPS - 1);
        end
        if (ctl.div_step)
        begin
            if (sub_ok)
            begin
                rem_reg <= rem_reg - dsr_reg;
            end
            str_reg <= {str_reg[scac_pkg::STRENGTH_W-2:0], sub_ok};
            dsr_reg <= dsr_reg >> 1;
        end
        if (ctl.out_load)
        begin
            res_dir_reg  <= dir_reg;
            res_str_reg  <= str_reg;
            res_min_reg  <= analog ? low_reg[idx] : '0;
            res_max_reg  <= analog ? high_reg[idx] : '0;
            res_seen_reg <= analog ? seen_reg[idx] : 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= '0;
            was_seen_reg <= 1'b0;
        end
        else if (ctl.update)
        begin
            was_seen_reg <= analog ? seen_reg[idx] : 1'b0;
            if (cmd_reg == scac_pkg::CMD_CLEAR)
            begin
                seen_reg <= '0;
            end
            else if (cmd_reg == scac_pkg::CMD_LOAD && analog)
            begin
                seen_reg[idx] <= load_seen_reg;
            end
            else if (cmd_reg == scac_pkg::CMD_CLASSIFY && analog)
            begin
                seen_reg[idx] <= 1'b1;
            end
        end
    end

    assign direction = res_dir_reg;
    assign strength  = res_str_reg;
    assign cal_min   = res_min_reg;
    assign cal_max   = res_max_reg;
    assign cal_seen  = res_seen_reg;

endmodule

// File: rtl/self_calibrating_axis_classifier.sv
// Top level of the self-calibrating axis classifier: joins controller and datapath.
// Depends on scac_pkg, scac_in_if, scac_out_if, scac_ctrl and scac_dp.
// Each transaction runs the update, prep, band and classify steps and, when needed, the
// strength divide, which retires one quotient bit a cycle on one shared subtractor.
// A new item is taken only after the result is loaded; an untaken result holds the next item.
// Reset clears the controller and the calibrated flags; min and max are undefined until written.
`timescale 1ns / 1ps

module self_calibrating_axis_classifier #(
    parameter int CAL_AXES   = scac_pkg::CAL_AXES,
    parameter int TOTAL_AXES = scac_pkg::TOTAL_AXES,
    parameter int POS_BITS   = scac_pkg::POS_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    scac_in_if.sink    sample,
    scac_out_if.source result
);

    scac_pkg::scac_ctrl_t ctl;
    scac_pkg::scac_stat_t stat;

    scac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    scac_dp #(
        .CAL_AXES   (CAL_AXES),
        .TOTAL_AXES (TOTAL_AXES),
        .POS_BITS   (POS_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .cmd       (sample.cmd),
        .axis      (sample.axis),
        .position  (sample.position),
        .hat_angle (sample.hat_angle),
        .load_min  (sample.load_min),
        .load_max  (sample.load_max),
        .load_seen (sample.load_seen),
        .direction (result.direction),
        .strength  (result.strength),
        .cal_min   (result.cal_min),
        .cal_max   (result.cal_max),
        .cal_seen  (result.cal_seen)
    );

    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(ctl))
        else $error("more than one datapath step commanded");

    a_accept_updates: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> ctl.update)
        else $error("accepted transaction not followed by the update step");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |=> result.valid)
        else $error("loaded result not presented");

    a_strength_max: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.strength <= scac_pkg::PERCENT))
        else $error("strength above one hundred");

endmodule

// File: dv/tb.sv
// Testbench for the self-calibrating axis classifier: directed and random sample traffic
// with random idling on both channels, checked against an in-bench predictor of each result.
// Depends on scac_pkg, scac_in_if, scac_out_if and self_calibrating_axis_classifier.
`timescale 1ns / 1ps

module tb;

    localparam logic [scac_pkg::CMD_W-1:0]  CMD_READ   = 2'd3;
    localparam logic [scac_pkg::AXIS_W-1:0] AXIS_HAT_X =
        scac_pkg::AXIS_W'(scac_pkg::CAL_AXES);
    localparam logic [scac_pkg::AXIS_W-1:0] AXIS_HAT_Y =
        scac_pkg::AXIS_W'(scac_pkg::CAL_AXES + 1);
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 30;
    localparam int RANDOM_ITEMS   = 1625;
    localparam int CALM_TAIL      = 200;

    typedef struct packed {
        logic [scac_pkg::CMD_W-1:0]    cmd;
        logic [scac_pkg::AXIS_W-1:0]   axis;
        logic [scac_pkg::POS_BITS-1:0] position;
        logic [scac_pkg::ANGLE_W-1:0]  hat_angle;
        logic [scac_pkg::POS_BITS-1:0] load_min;
        logic [scac_pkg::POS_BITS-1:0] load_max;
        logic                          load_seen;
    } axis_sample_t;

    typedef struct packed {
        logic [scac_pkg::DIR_W-1:0]      direction;
        logic [scac_pkg::STRENGTH_W-1:0] strength;
        logic [scac_pkg::POS_BITS-1:0]   cal_min;
        logic [scac_pkg::POS_BITS-1:0]   cal_max;
        logic                            cal_seen;
    } axis_report_t;

    logic clk = 1'b0;
    logic rst_n;

    scac_in_if  sample_if ();
    scac_out_if result_if ();

    self_calibrating_axis_classifier dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_if),
        .result (result_if)
    );

    logic [scac_pkg::POS_BITS-1:0] track_min     [scac_pkg::CAL_AXES];
    logic [scac_pkg::POS_BITS-1:0] track_max     [scac_pkg::CAL_AXES];
    logic                          track_seen    [scac_pkg::CAL_AXES];
    bit                            track_written [scac_pkg::CAL_AXES];

    axis_report_t pending_reports [$];

    int failures        = 0;
    int reports_checked = 0;
    int analog_items    = 0;
    int hat_items       = 0;
    int command_items   = 0;
    int effective_items = 0;
    bit src_idle_en     = 1'b1;
    bit sink_stall_en   = 1'b1;

    always #2 clk = ~clk;

    function automatic int hat_level_of(input logic [scac_pkg::ANGLE_W-1:0] angle,
                                        input logic vertical);
        int  deg;
        real rad;
        if (angle == scac_pkg::HAT_CENTRED)
        begin
            return 100;
        end
        deg = (angle / 100) % 360;
        rad = real'(deg) * 3.141592653589793 / 180.0;
        if (vertical)
        begin
            return $rtoi(100.0 - 100.0 * $cos(rad));
        end
        return $rtoi(100.0 + 100.0 * $sin(rad));
    endfunction

    function automatic axis_report_t predict_report(input axis_sample_t s);
        axis_report_t r;
        int unsigned  pos;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        int unsigned  span;
        int unsigned  band;
        int           level;
        logic         analog;
        r      = '0;
        pos    = s.position;
        analog = (s.axis < scac_pkg::CAL_AXES);
        if (s.cmd == scac_pkg::CMD_CLEAR)
        begin
            for (int i = 0; i < scac_pkg::CAL_AXES; i++)
            begin
                track_seen[i] = 1'b0;
            end
        end
        else if (s.cmd == scac_pkg::CMD_LOAD && analog)
        begin
            track_min[s.axis]     = s.load_min;
            track_max[s.axis]     = s.load_max;
            track_seen[s.axis]    = s.load_seen;
            track_written[s.axis] = 1'b1;
        end
        else if (s.cmd == scac_pkg::CMD_CLASSIFY && analog)
        begin
            if (!track_seen[s.axis])
            begin
                track_min[s.axis]     = s.position;
                track_max[s.axis]     = s.position;
                track_seen[s.axis]    = 1'b1;
                track_written[s.axis] = 1'b1;
            end
            else
            begin
                if (pos < track_min[s.axis])
                begin
                    track_min[s.axis] = s.position;
                end
                if (pos > track_max[s.axis])
                begin
                    track_max[s.axis] = s.position;
                end
                lo   = track_min[s.axis];
                hi   = track_max[s.axis];
                mid  = (lo + hi) / 2;
                span = hi - mid;
                band = span / 5;
                if (pos + band < mid)
                begin
                    r.direction = scac_pkg::DIR_LOW;
                    if (span != 0)
                    begin
                        r.strength = scac_pkg::STRENGTH_W'((mid - pos) * 100 / span);
                    end
                end
                else if (pos > mid + band)
                begin
                    r.direction = scac_pkg::DIR_HIGH;
                    if (span != 0)
                    begin
                        r.strength = scac_pkg::STRENGTH_W'((pos - mid) * 100 / span);
                    end
                end
            end
        end
        else if (s.cmd == scac_pkg::CMD_CLASSIFY && s.axis < scac_pkg::TOTAL_AXES)
        begin
            level      = hat_level_of(s.hat_angle, s.axis == AXIS_HAT_Y);
            r.strength = scac_pkg::STRENGTH_W'((level >= 100) ? level - 100 : 100 - level);
            if (level > 130)
            begin
                r.direction = scac_pkg::DIR_HIGH;
            end
            else if (level < 70)
            begin
                r.direction = scac_pkg::DIR_LOW;
            end
        end
        if (analog)
        begin
            r.cal_min  = track_min[s.axis];
            r.cal_max  = track_max[s.axis];
            r.cal_seen = track_seen[s.axis];
        end
        return r;
    endfunction

    function automatic axis_sample_t make_sample(
        input logic [scac_pkg::CMD_W-1:0]    cmd,
        input logic [scac_pkg::AXIS_W-1:0]   axis,
        input logic [scac_pkg::POS_BITS-1:0] position,
        input logic [scac_pkg::ANGLE_W-1:0]  angle,
        input logic [scac_pkg::POS_BITS-1:0] load_min,
        input logic [scac_pkg::POS_BITS-1:0] load_max,
        input logic                          load_seen);
        axis_sample_t s;
        s.cmd       = cmd;
        s.axis      = axis;
        s.position  = position;
        s.hat_angle = angle;
        s.load_min  = load_min;
        s.load_max  = load_max;
        s.load_seen = load_seen;
        return s;
    endfunction

    function automatic logic [scac_pkg::ANGLE_W-1:0] random_angle();
        logic [scac_pkg::ANGLE_W-1:0] angle;
        case ($urandom_range(0, 5))
            0:
            begin
                angle = scac_pkg::HAT_CENTRED;
            end
            1, 2:
            begin
                angle = scac_pkg::ANGLE_W'($urandom_range(0, 654) * 100
                                           + $urandom_range(0, 99));
            end
            default:
            begin
                angle = scac_pkg::ANGLE_W'($urandom);
            end
        endcase
        return angle;
    endfunction

    // Clear and read-back report the stored range, so they address only analog axes written before, or hat axes.
    function automatic axis_sample_t random_sample();
        axis_sample_t s;
        int unsigned  pick;
        pick        = $urandom_range(0, 99);
        s.cmd       = (pick < 60) ? scac_pkg::CMD_CLASSIFY : (pick < 64) ? scac_pkg::CMD_CLEAR :
                      (pick < 82) ? scac_pkg::CMD_LOAD : CMD_READ;
        s.axis      = scac_pkg::AXIS_W'($urandom_range(0, 7));
        s.position  = scac_pkg::POS_BITS'($urandom);
        s.hat_angle = random_angle();
        s.load_min  = scac_pkg::POS_BITS'($urandom);
        s.load_max  = scac_pkg::POS_BITS'($urandom);
        s.load_seen = 1'($urandom_range(0, 1));
        if ((s.cmd == scac_pkg::CMD_CLEAR || s.cmd == CMD_READ) &&
            s.axis < scac_pkg::CAL_AXES && !track_written[s.axis])
        begin
            s.axis = scac_pkg::AXIS_W'(scac_pkg::CAL_AXES + $urandom_range(0, 1));
        end
        return s;
    endfunction

    task automatic send_sample(input axis_sample_t s);
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            sample_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        sample_if.valid     <= 1'b1;
        sample_if.cmd       <= s.cmd;
        sample_if.axis      <= s.axis;
        sample_if.position  <= s.position;
        sample_if.hat_angle <= s.hat_angle;
        sample_if.load_min  <= s.load_min;
        sample_if.load_max  <= s.load_max;
        sample_if.load_seen <= s.load_seen;
        @(posedge clk);
        while (sample_if.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        pending_reports.push_back(predict_report(s));
        if (s.cmd == scac_pkg::CMD_CLASSIFY && s.axis < scac_pkg::CAL_AXES)
        begin
            analog_items++;
        end
        else if (s.cmd == scac_pkg::CMD_CLASSIFY)
        begin
            hat_items++;
        end
        else
        begin
            command_items++;
        end
        if (!((s.cmd == scac_pkg::CMD_LOAD || s.cmd == CMD_READ) &&
              s.axis >= scac_pkg::CAL_AXES))
        begin
            effective_items++;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            failures++;
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_checker
        axis_report_t want;
        if (rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1)
        begin
            reports_checked++;
            if (pending_reports.size() == 0)
            begin
                failures++;
                $error("result transaction with no sample transaction waiting for it");
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("direction", 32'(want.direction), 32'(result_if.direction));
                check_field("strength", 32'(want.strength), 32'(result_if.strength));
                check_field("cal_min", 32'(want.cal_min), 32'(result_if.cal_min));
                check_field("cal_max", 32'(want.cal_max), 32'(result_if.cal_max));
                check_field("cal_seen", 32'(want.cal_seen), 32'(result_if.cal_seen));
            end
        end
    end

    initial
    begin : result_sink
        int burst;
        result_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (sink_stall_en && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(1, 18);
                result_if.ready <= 1'b0;
                repeat (burst) @(posedge clk);
            end
            else
            begin
                result_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((sample_if.valid === 1'b1 && sample_if.ready === 1'b1) ||
                (result_if.valid === 1'b1 && result_if.ready === 1'b1))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("Timed out after %0d cycles without a transaction.", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    task automatic test_analog_calibration();
        send_sample(make_sample(scac_pkg::CMD_CLASSIFY, 3'd0, 16'd1000, 16'd0, 16'd0, 16'd0,
                                1'b0));
        send_sample(make_sample(scac_pkg::CMD_CLASSIFY, 3'd0, 16'd1000, 16'd0, 16'd0, 16'd0,
                                1'b0));
        send_sample(make_sample(scac_pkg::CMD_CLASSIFY, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                                1'b0));
        send_sample(make_sample(scac_pkg::CMD_CLASSIFY, 3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                16'hFFFF, 1'b1));
        send_sample(make_sample(scac_pkg::CMD_CLASSIFY, 3'd0, 16'd26214, 16'd0, 16'd0, 16'd0,
                                1'b0));
        send_sample(make_sample(scac_pkg::CMD_CLASSIFY, 3'd0, 16'd26213, 16'd0, 16'd0, 16'd0,
                                1'b0));
        send_sample(make_sample(scac_pkg::CMD_CLASSIFY, 3'd0, 16'd39322, 16'd0, 16'd0, 16'd0,
                                1'b0));
    endtask

    task automatic test_commands();
        send_sample(make_sample(scac_pkg::CMD_LOAD, 3'd1, 16'd0, 16'd0, 16'd0, 16'hFFFF,
                                1'b1));
        send_sample(make_sample(scac_pkg::CMD_LOAD, 3'd2, 16'd0, 16'd0, 16'hFFFF, 16'd0,
                                1'b0));
        send_sample(make_sample(CMD_READ, 3'd2, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
        send_sample(make_sample(scac_pkg::CMD_CLASSIFY, 3'd2, 16'd40000, 16'd0, 16'd0, 16'd0,
                                1'b0));
        send_sample(make_sample(scac_pkg::CMD_LOAD, 3'd3, 16'd0, 16'd0, 16'd500, 16'd500,
                                1'b1));
        send_sample(make_sample(scac_pkg::CMD_CLASSIFY, 3'd3, 16'd500, 16'd0, 16'd0, 16'd0,
                                1'b0));
        send_sample(make_sample(scac_pkg::CMD_LOAD, AXIS_HAT_X, 16'd7, 16'd9000, 16'd1, 16'd2,
                                1'b1));
        send_sample(make_sample(scac_pkg::CMD_CLEAR, 3'd1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
        send_sample(make_sample(scac_pkg::CMD_CLASSIFY, 3'd1, 16'd12345, 16'd0, 16'd0, 16'd0,
                                1'b0));
        send_sample(make_sample(scac_pkg::CMD_LOAD, 3'd5, 16'd0, 16'd0, 16'd100, 16'd50,
                                1'b1));
        send_sample(make_sample(scac_pkg::CMD_CLASSIFY, 3'd5, 16'd75, 16'd0, 16'd0, 16'd0,
                                1'b0));
    endtask

    task automatic test_hat_switch();
        send_sample(make_sample(scac_pkg::CMD_CLASSIFY, AXIS_HAT_X, 16'd0,
                                scac_pkg::HAT_CENTRED, 16'd0, 16'd0, 1'b0));
        send_sample(make_sample(scac_pkg::CMD_CLASSIFY, AXIS_HAT_X, 16'd0, 16'd9000,
                                16'd0, 16'd0, 1'b0));
        send_sample(make_sample(scac_pkg::CMD_CLASSIFY, AXIS_HAT_X, 16'd0, 16'd27000,
                                16'd0, 16'd0, 1'b0));
        send_sample(make_sample(scac_pkg::CMD_CLASSIFY, AXIS_HAT_X, 16'd0, 16'd18000,
                                16'd0, 16'd0, 1'b0));
        send_sample(make_sample(scac_pkg::CMD_CLASSIFY, AXIS_HAT_X, 16'd0, 16'd21099,
                                16'd0, 16'd0, 1'b0));
        send_sample(make_sample(scac_pkg::CMD_CLASSIFY, AXIS_HAT_X, 16'd0, 16'd65534,
                                16'd0, 16'd0, 1'b0));
        send_sample(make_sample(scac_pkg::CMD_CLASSIFY, AXIS_HAT_X, 16'd0, 16'd65499,
                                16'd0, 16'd0, 1'b0));
        send_sample(make_sample(scac_pkg::CMD_CLASSIFY, AXIS_HAT_Y, 16'd0, 16'd0,
                                16'd0, 16'd0, 1'b0));
        send_sample(make_sample(scac_pkg::CMD_CLASSIFY, AXIS_HAT_Y, 16'd0, 16'd12000,
                                16'd0, 16'd0, 1'b0));
        send_sample(make_sample(scac_pkg::CMD_CLASSIFY, AXIS_HAT_Y, 16'd0, 16'd6000,
                                16'd0, 16'd0, 1'b0));
        send_sample(make_sample(scac_pkg::CMD_CLASSIFY, AXIS_HAT_Y, 16'd0, 16'd39000,
                                16'd0, 16'd0, 1'b0));
    endtask

    // Most episodes calibrate one axis and then sweep samples across a chosen span.
    task automatic test_random_traffic(input int total);
        int                            first;
        int                            mode;
        int                            burst;
        int                            start;
        int unsigned                   base;
        int unsigned                   top;
        logic [scac_pkg::AXIS_W-1:0]   ax;
        logic [scac_pkg::POS_BITS-1:0] pos;
        first = effective_items;
        while (effective_items - first < total)
        begin
            if (total - (effective_items - first) <= CALM_TAIL)
            begin
                src_idle_en   = 1'b0;
                sink_stall_en = 1'b0;
            end
            else
            begin
                mode          = $urandom_range(0, 3);
                src_idle_en   = mode[0];
                sink_stall_en = mode[1];
            end
            burst = $urandom_range(4, 24);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    ax   = scac_pkg::AXIS_W'($urandom_range(0, scac_pkg::CAL_AXES - 1));
                    base = $urandom_range(0, 65535);
                    top  = base + (32'd1 << $urandom_range(0, 16)) - 1;
                    if (top > 65535)
                    begin
                        top = 65535;
                    end
                    start = $urandom_range(0, 2);
                    if (start < 2)
                    begin
                        send_sample(make_sample(scac_pkg::CMD_LOAD, ax,
                                                scac_pkg::POS_BITS'($urandom), random_angle(),
                                                scac_pkg::POS_BITS'(base),
                                                scac_pkg::POS_BITS'(top), start == 0));
                    end
                    repeat (burst)
                    begin
                        if ($urandom_range(0, 7) == 0)
                        begin
                            send_sample(random_sample());
                        end
                        else
                        begin
                            pos = ($urandom_range(0, 15) == 0) ?
                                  scac_pkg::POS_BITS'($urandom) :
                                  scac_pkg::POS_BITS'($urandom_range(base, top));
                            send_sample(make_sample(scac_pkg::CMD_CLASSIFY, ax, pos,
                                                    random_angle(),
                                                    scac_pkg::POS_BITS'($urandom),
                                                    scac_pkg::POS_BITS'($urandom),
                                                    1'($urandom_range(0, 1))));
                        end
                    end
                end
                6, 7:
                begin
                    repeat (burst)
                    begin
                        send_sample(make_sample(scac_pkg::CMD_CLASSIFY,
                                                ($urandom_range(0, 1) == 0) ? AXIS_HAT_X
                                                                            : AXIS_HAT_Y,
                                                scac_pkg::POS_BITS'($urandom), random_angle(),
                                                scac_pkg::POS_BITS'($urandom),
                                                scac_pkg::POS_BITS'($urandom),
                                                1'($urandom_range(0, 1))));
                    end
                end
                default:
                begin
                    repeat (burst) send_sample(random_sample());
                end
            endcase
        end
    endtask

    initial
    begin : run
        rst_n               <= 1'b0;
        sample_if.valid     <= 1'b0;
        sample_if.cmd       <= scac_pkg::CMD_CLASSIFY;
        sample_if.axis      <= '0;
        sample_if.position  <= '0;
        sample_if.hat_angle <= '0;
        sample_if.load_min  <= '0;
        sample_if.load_max  <= '0;
        sample_if.load_seen <= 1'b0;
        for (int i = 0; i < scac_pkg::CAL_AXES; i++)
        begin
            track_seen[i]    = 1'b0;
            track_written[i] = 1'b0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_analog_calibration();
        test_commands();
        test_hat_switch();
        test_random_traffic(RANDOM_ITEMS);
        sample_if.valid <= 1'b0;
        while (pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d analog samples, %0d hat samples and %0d clear, load or read commands.",
                 analog_items, hat_items, command_items);
        $display("Checked %0d results for direction, strength and stored calibration; %0d errors.",
                 reports_checked, failures);
        if (failures == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
